// ===== rtl/msj_pkg.sv =====
// Shared types and constants for the multiway sorted key join step.
// No dependencies.
`default_nettype none
package msj_pkg;

  localparam int LANE_MAX   = 4;
  localparam int REC_W      = 56;
  localparam int KEY_W      = 40;
  localparam int KEY_LSB    = 16;
  localparam int ALLELE1_LSB = 8;
  localparam int ALLELE2_LSB = 0;
  localparam int CNT_W      = 3;
  localparam int LANE_IDX_W = 2;
  localparam logic [CNT_W-1:0] MIN_LANES   = 3'd2;
  localparam logic [CNT_W-1:0] RESET_LANES = 3'd4;
  localparam logic [2:0] MAX_CODES = 3'd2;

  typedef logic [REC_W-1:0] rec_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [LANE_IDX_W-1:0] lane_idx_t;
  typedef logic [LANE_MAX-1:0] lane_mask_t;

  // Per-item lane findings handed to the merge stage.
  typedef struct packed {
    lane_mask_t                   act;
    lane_mask_t                   match;
    lane_mask_t                   full;
    logic [LANE_MAX-1:0][LANE_MAX-1:0] gt;   // gt[i][j]: key i > key j
  } stage_t;

  typedef struct packed {
    logic       joined;
    lane_idx_t  rep;
    lane_idx_t  great;
    lane_mask_t adv;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/multiway_sorted_key_join_step_top.sv =====
// Top level of the multiway sorted key join step: lane checkers, pairwise
// key compare, merge stage and output register. Depends on msj_pkg,
// msj_lane and msj_merge.
//
// One join decision per item, one item per clock while out_ready stays
// high. A result passes two registers: the first holds the per-lane
// match, allele and pairwise key compare findings, the second
// holds the merged decision. Input ready drops only while both registers
// hold undelivered results. active_lanes is clamped to 2..LANES; write it
// only while no item is in flight.
`default_nettype none
module multiway_sorted_key_join_step_top #(
  parameter int LANES            = 4,
  parameter int ALLELE_CODE_BITS = 8
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        active_lanes_we,
  input  wire [2:0]  active_lanes,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire [55:0] lane_0_record,
  input  wire [55:0] lane_1_record,
  input  wire [55:0] lane_2_record,
  input  wire [55:0] lane_3_record,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       joined,
  output logic [1:0] representative_lane,
  output logic [1:0] greatest_lane,
  output logic [3:0] advance_mask
);

  localparam logic [msj_pkg::CNT_W-1:0] LANES_C = msj_pkg::CNT_W'(LANES);

  logic [msj_pkg::CNT_W-1:0] lane_cfg;
  logic [msj_pkg::CNT_W-1:0] lane_n;
  msj_pkg::rec_t             recs [msj_pkg::LANE_MAX];
  msj_pkg::key_t             keys [msj_pkg::LANE_MAX];
  msj_pkg::stage_t           s1_next;
  msj_pkg::stage_t           s1;
  logic                      s1_valid;
  logic                      s1_move;
  msj_pkg::result_t          res;
  msj_pkg::lane_mask_t       lane_match;
  msj_pkg::lane_mask_t       lane_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_cfg <= msj_pkg::RESET_LANES;
    end else if (active_lanes_we) begin
      lane_cfg <= active_lanes;
    end
  end

  always_comb begin
    if (lane_cfg < msj_pkg::MIN_LANES) begin
      lane_n = msj_pkg::MIN_LANES;
    end else if (lane_cfg > LANES_C) begin
      lane_n = LANES_C;
    end else begin
      lane_n = lane_cfg;
    end
  end

  assign recs[0] = lane_0_record;
  assign recs[1] = lane_1_record;
  assign recs[2] = lane_2_record;
  assign recs[3] = lane_3_record;

  for (genvar g = 0; g < msj_pkg::LANE_MAX; g++) begin : g_lane
    assign keys[g] = recs[g][msj_pkg::KEY_LSB +: msj_pkg::KEY_W];
    if (g < LANES) begin : g_on
      msj_lane #(
        .ALLELE_CODE_BITS(ALLELE_CODE_BITS)
      ) u_lane (
        .rec     (recs[g]),
        .ref_rec (recs[0]),
        .match   (lane_match[g]),
        .full    (lane_full[g])
      );
    end else begin : g_off
      assign lane_match[g] = 1'b0;
      assign lane_full[g]  = 1'b0;
    end
  end

  always_comb begin
    s1_next.match = lane_match;
    s1_next.full  = lane_full;
    for (int i = 0; i < msj_pkg::LANE_MAX; i++) begin
      s1_next.act[i] = (msj_pkg::CNT_W'(i) < lane_n);
      for (int j = 0; j < msj_pkg::LANE_MAX; j++) begin
        s1_next.gt[i][j] = (keys[i] > keys[j]);
      end
    end
  end

  // Two-register pipeline; each stage loads when its downstream slot frees.
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1 <= s1_next;
    end
  end

  msj_merge u_merge (
    .s   (s1),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      joined              <= res.joined;
      representative_lane <= res.rep;
      greatest_lane       <= res.great;
      advance_mask        <= res.adv;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/msj_lane.sv =====
// One lane checker: locus equality against lane 0 and allele code count.
// Depends on msj_pkg.
`default_nettype none
module msj_lane #(
  parameter int ALLELE_CODE_BITS = 8
) (
  input  wire msj_pkg::rec_t rec,
  input  wire msj_pkg::rec_t ref_rec,
  output logic               match,
  output logic               full
);

  typedef logic [ALLELE_CODE_BITS-1:0] code_t;

  code_t      codes [4];
  logic [3:0] nz;
  logic [3:0] fresh;
  logic [2:0] distinct;
  logic       key_eq;

  always_comb begin
    codes[0] = rec[msj_pkg::ALLELE1_LSB +: ALLELE_CODE_BITS];
    codes[1] = rec[msj_pkg::ALLELE2_LSB +: ALLELE_CODE_BITS];
    codes[2] = ref_rec[msj_pkg::ALLELE1_LSB +: ALLELE_CODE_BITS];
    codes[3] = ref_rec[msj_pkg::ALLELE2_LSB +: ALLELE_CODE_BITS];
    distinct = 3'd0;
    for (int k = 0; k < 4; k++) begin
      nz[k]    = (codes[k] != '0);
      fresh[k] = nz[k];
      for (int j = 0; j < k; j++) begin
        if (codes[j] == codes[k]) begin
          fresh[k] = 1'b0;
        end
      end
      distinct = distinct + {2'b00, fresh[k]};
    end
    key_eq = (rec[msj_pkg::KEY_LSB +: msj_pkg::KEY_W] ==
              ref_rec[msj_pkg::KEY_LSB +: msj_pkg::KEY_W]);
    match  = key_eq && (distinct <= msj_pkg::MAX_CODES);
    full   = nz[0] && nz[1];
  end

endmodule
`default_nettype wire

// ===== rtl/msj_merge.sv =====
// Merge stage: combines lane findings into match flag, representative,
// greatest lane and advance mask. Depends on msj_pkg.
`default_nettype none
module msj_merge (
  input  wire msj_pkg::stage_t  s,
  output msj_pkg::result_t      res
);

  logic                 all_m;
  logic                 found;
  msj_pkg::lane_idx_t   rep;
  msj_pkg::lane_idx_t   great;
  msj_pkg::lane_mask_t  adv;

  always_comb begin
    all_m = 1'b1;
    found = 1'b0;
    rep   = '0;
    great = '0;
    adv   = '0;
    for (int i = 1; i < msj_pkg::LANE_MAX; i++) begin
      if (s.act[i] && !s.match[i]) begin
        all_m = 1'b0;
      end
      if (s.act[i] && s.gt[i][great]) begin
        great = msj_pkg::LANE_IDX_W'(i);
      end
    end
    for (int i = 0; i < msj_pkg::LANE_MAX; i++) begin
      if (all_m) begin
        adv[i] = s.act[i];
        if (s.act[i] && s.full[i] && !found) begin
          rep   = msj_pkg::LANE_IDX_W'(i);
          found = 1'b1;
        end
      end else begin
        adv[i] = s.act[i] && s.gt[great][i];
      end
    end
    res.joined = all_m;
    res.rep    = all_m ? rep : '0;
    res.great  = great;
    res.adv    = adv;
  end

endmodule
`default_nettype wire

// ===== dv/tb_multiway_sorted_key_join_step_top.sv =====
// Self-checking testbench for multiway_sorted_key_join_step_top: directed table
// plus random lane heads over every lane-count setting, scored against a local
// join-decision predictor. Depends on msj_pkg and the RTL under rtl/.
module tb_multiway_sorted_key_join_step_top;

  localparam int LANES       = msj_pkg::LANE_MAX;
  localparam int CODE_BITS   = 8;
  localparam int HOLD_CYCLES = 64;
  localparam int PHASE_ITEMS = 241;
  localparam int N_ROWS      = 24;

  typedef msj_pkg::rec_t [msj_pkg::LANE_MAX-1:0] heads_t;

  typedef struct packed {
    logic [msj_pkg::CNT_W-1:0] lanes;
    heads_t                    heads;   // {lane 3, lane 2, lane 1, lane 0}
    logic                      typed;
    msj_pkg::result_t          want;
  } step_row_t;

  localparam msj_pkg::rec_t R_ZERO = '0;
  localparam msj_pkg::rec_t R_ONES = '1;
  localparam msj_pkg::rec_t R_KMAX = 56'hFF_FFFFFFFF_00_00;

  localparam step_row_t STEP_ROWS [N_ROWS] = '{
    '{3'd4, {R_ZERO, R_ZERO, R_ZERO, R_ZERO},
      1'b1, '{1'b1, 2'd0, 2'd0, 4'hF}},
    '{3'd4, {R_ONES, R_ONES, R_ONES, R_ONES},
      1'b1, '{1'b1, 2'd0, 2'd0, 4'hF}},
    '{3'd4, {R_ZERO, R_ZERO, R_ZERO, R_KMAX},
      1'b1, '{1'b0, 2'd0, 2'd0, 4'hE}},
    '{3'd4, {R_KMAX, R_ZERO, R_ZERO, R_ZERO},
      1'b1, '{1'b0, 2'd0, 2'd3, 4'h7}},
    // tie for the greatest key: first lane wins
    '{3'd4, {R_ZERO, R_KMAX, R_KMAX, R_ZERO},
      1'b1, '{1'b0, 2'd0, 2'd1, 4'h9}},
    '{3'd4, {R_KMAX, R_KMAX, R_KMAX, R_ZERO},
      1'b1, '{1'b0, 2'd0, 2'd1, 4'h1}},
    // chromosome outranks position
    '{3'd4, {56'h00_00000000_00_00, 56'h01_00000000_00_00,
             56'h00_FFFFFFFF_00_00, 56'h01_00000000_00_00},
      1'b0, '0},
    '{3'd4, {R_ZERO, R_ZERO, R_ZERO, 56'h00_00000001_00_00},
      1'b0, '0},
    // equal keys, three distinct codes
    '{3'd4, {56'h05_00001234_01_02, 56'h05_00001234_01_02,
             56'h05_00001234_03_00, 56'h05_00001234_01_02},
      1'b1, '{1'b0, 2'd0, 2'd0, 4'h0}},
    '{3'd4, {56'h05_00001234_07_07, 56'h05_00001234_05_07,
             56'h05_00001234_05_00, 56'h05_00001234_00_00},
      1'b0, '0},
    '{3'd4, {56'h05_00001234_01_02, 56'h05_00001234_00_00,
             56'h05_00001234_00_01, 56'h05_00001234_01_00},
      1'b0, '0},
    '{3'd4, {56'h22_00ABCDEF_0A_09, 56'h22_00ABCDEF_0A_0A,
             56'h22_00ABCDEF_09_0A, 56'h22_00ABCDEF_09_09},
      1'b0, '0},
    // each lane agrees with lane 0 alone, not with the others
    '{3'd4, {56'h07_00000100_05_06, 56'h07_00000100_03_04,
             56'h07_00000100_01_02, 56'h07_00000100_00_00},
      1'b0, '0},
    '{3'd4, {56'hFF_FFFFFFFF_00_01, 56'hFF_FFFFFFFF_FF_FF,
             56'hFF_FFFFFFFF_01_FF, 56'hFF_FFFFFFFF_FF_01},
      1'b0, '0},
    '{3'd2, {R_ONES, R_KMAX, 56'h10_00000010_04_04, 56'h10_00000010_04_04},
      1'b1, '{1'b1, 2'd0, 2'd0, 4'h3}},
    '{3'd2, {R_ZERO, R_ZERO, R_KMAX, R_ZERO},
      1'b1, '{1'b0, 2'd0, 2'd1, 4'h1}},
    '{3'd3, {R_KMAX, R_ZERO, R_ZERO, R_ZERO},
      1'b1, '{1'b1, 2'd0, 2'd0, 4'h7}},
    '{3'd3, {R_ZERO, 56'h00_00000001_00_00, R_ZERO, R_ZERO},
      1'b0, '0},
    // lane count below range
    '{3'd0, {R_ONES, R_KMAX, 56'h10_00000010_04_04, 56'h10_00000010_04_04},
      1'b1, '{1'b1, 2'd0, 2'd0, 4'h3}},
    '{3'd1, {R_ZERO, R_ONES, R_ZERO, R_KMAX},
      1'b1, '{1'b0, 2'd0, 2'd0, 4'h2}},
    // lane count above range
    '{3'd7, {R_KMAX, R_ZERO, R_ZERO, R_ZERO},
      1'b1, '{1'b0, 2'd0, 2'd3, 4'h7}},
    '{3'd5, {56'h05_00001234_04_04, 56'h05_00001234_03_03,
             56'h05_00001234_00_00, 56'h05_00001234_00_00},
      1'b0, '0},
    '{3'd6, {R_ONES, R_ONES, R_ONES, R_ONES},
      1'b1, '{1'b1, 2'd0, 2'd0, 4'hF}},
    '{3'd6, {56'h80_00000000_80_01, 56'h80_00000000_01_80,
             R_KMAX, 56'h7F_FFFFFFFF_80_80},
      1'b0, '0}
  };

  localparam logic [msj_pkg::CNT_W-1:0] PHASE_LANES [8] =
    '{3'd4, 3'd2, 3'd7, 3'd3, 3'd0, 3'd5, 3'd1, 3'd6};

  logic                      clk;
  logic                      rst;
  logic                      lanes_we;
  logic [msj_pkg::CNT_W-1:0] lanes_wr_data;
  logic                      in_valid;
  logic                      in_ready;
  msj_pkg::rec_t             lane_0_record;
  msj_pkg::rec_t             lane_1_record;
  msj_pkg::rec_t             lane_2_record;
  msj_pkg::rec_t             lane_3_record;
  logic                      out_valid;
  logic                      out_ready;
  logic                      joined;
  msj_pkg::lane_idx_t        representative_lane;
  msj_pkg::lane_idx_t        greatest_lane;
  msj_pkg::lane_mask_t       advance_mask;

  msj_pkg::result_t          decision_q [$];
  msj_pkg::result_t          head_want;
  logic [msj_pkg::CNT_W-1:0] lanes_now;
  bit                        idle_on;
  int                        stall_reqs;
  int                        stalls_done;
  int                        mismatches;
  int                        n_in;
  int                        n_out;
  int                        n_joins;

  multiway_sorted_key_join_step_top #(
    .LANES(LANES),
    .ALLELE_CODE_BITS(CODE_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .active_lanes_we(lanes_we),
    .active_lanes(lanes_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .lane_0_record(lane_0_record),
    .lane_1_record(lane_1_record),
    .lane_2_record(lane_2_record),
    .lane_3_record(lane_3_record),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .joined(joined),
    .representative_lane(representative_lane),
    .greatest_lane(greatest_lane),
    .advance_mask(advance_mask)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic msj_pkg::result_t join_decision(input heads_t h,
                                                     input logic [msj_pkg::CNT_W-1:0] cfg);
    int n;
    int g;
    int seen;
    bit dup;
    bit all_ok;
    bit found;
    msj_pkg::key_t k [msj_pkg::LANE_MAX];
    logic [CODE_BITS-1:0] c [4];
    msj_pkg::result_t r;
    n = (cfg < msj_pkg::MIN_LANES) ? int'(msj_pkg::MIN_LANES) :
        (cfg > LANES) ? LANES : int'(cfg);
    for (int i = 0; i < msj_pkg::LANE_MAX; i++) k[i] = h[i][msj_pkg::KEY_LSB +: msj_pkg::KEY_W];
    r = '0;
    all_ok = 1'b1;
    for (int i = 1; i < n; i++) begin
      c[0] = h[i][msj_pkg::ALLELE1_LSB +: CODE_BITS];
      c[1] = h[i][msj_pkg::ALLELE2_LSB +: CODE_BITS];
      c[2] = h[0][msj_pkg::ALLELE1_LSB +: CODE_BITS];
      c[3] = h[0][msj_pkg::ALLELE2_LSB +: CODE_BITS];
      seen = 0;
      for (int a = 0; a < 4; a++) begin
        dup = 1'b0;
        for (int b = 0; b < a; b++) if (c[b] == c[a]) dup = 1'b1;
        if (c[a] != '0 && !dup) seen++;
      end
      if (k[i] != k[0] || seen > msj_pkg::MAX_CODES) all_ok = 1'b0;
    end
    g = 0;
    for (int i = 1; i < n; i++) if (k[i] > k[g]) g = i;
    r.joined = all_ok;
    r.great = msj_pkg::lane_idx_t'(g);
    found = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (all_ok) begin
        r.adv[i] = 1'b1;
        if (!found && h[i][msj_pkg::ALLELE1_LSB +: CODE_BITS] != '0 &&
            h[i][msj_pkg::ALLELE2_LSB +: CODE_BITS] != '0) begin
          r.rep = msj_pkg::lane_idx_t'(i);
          found = 1'b1;
        end
      end else if (k[i] < k[g]) begin
        r.adv[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [CODE_BITS-1:0] pool_code(input logic [CODE_BITS-1:0] c0,
                                                     input logic [CODE_BITS-1:0] c1);
    case ($urandom_range(0, 2))
      0: return '0;
      1: return c0;
      default: return c1;
    endcase
  endfunction

  // mostly shared-locus groups with compatible alleles, some near keys, some noise
  function automatic heads_t random_heads();
    msj_pkg::key_t base;
    msj_pkg::key_t k;
    logic [CODE_BITS-1:0] c0;
    logic [CODE_BITS-1:0] c1;
    logic [CODE_BITS-1:0] c2;
    heads_t h;
    int mode;
    int j;
    int s;
    base = msj_pkg::KEY_W'({$urandom, $urandom});
    case ($urandom_range(0, 7))
      0: base[39:32] = '0;
      1: base[39:32] = '1;
      2: base[31:0] = '0;
      3: base[31:0] = '1;
      default: ;
    endcase
    c0 = CODE_BITS'($urandom_range(1, 255));
    c1 = ($urandom_range(0, 3) == 0) ? c0 : CODE_BITS'($urandom_range(1, 255));
    c2 = CODE_BITS'($urandom_range(1, 255));
    mode = $urandom_range(0, 99);
    for (int i = 0; i < msj_pkg::LANE_MAX; i++) begin
      k = base;
      if (mode >= 45 && mode < 75) begin
        case ($urandom_range(0, 5))
          0: k = base - 1;
          1: k = base + 1;
          2: k = base + 40'h1_0000_0000;
          default: ;
        endcase
      end
      h[i] = {k, pool_code(c0, c1), pool_code(c0, c1)};
      if (mode >= 75) h[i] = msj_pkg::REC_W'({$urandom, $urandom});
    end
    if (mode < 45 && $urandom_range(0, 3) == 0) begin
      j = $urandom_range(0, msj_pkg::LANE_MAX - 1);
      s = $urandom_range(0, 1) ? msj_pkg::ALLELE1_LSB : msj_pkg::ALLELE2_LSB;
      h[j][s +: CODE_BITS] = c2;
    end
    return h;
  endfunction

  task automatic send_heads(input heads_t h, input bit typed, input msj_pkg::result_t want);
    while (idle_on && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    lane_0_record <= h[0];
    lane_1_record <= h[1];
    lane_2_record <= h[2];
    lane_3_record <= h[3];
    do @(posedge clk); while (!in_ready);
    decision_q.push_back(typed ? want : join_decision(h, lanes_now));
    n_in++;
  endtask

  task automatic write_lanes(input logic [msj_pkg::CNT_W-1:0] v);
    in_valid <= 1'b0;
    while (decision_q.size() != 0) @(posedge clk);
    lanes_we      <= 1'b1;
    lanes_wr_data <= v;
    @(posedge clk);
    lanes_we  <= 1'b0;
    lanes_now = v;
  endtask

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    stalls_done = 0;
    forever begin
      @(posedge clk);
      if (stall_reqs != stalls_done) begin
        stalls_done++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= !(idle_on && $urandom_range(0, 99) < 31);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (decision_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result transfer match=%0d rep=%0d great=%0d adv=%h",
                   joined, representative_lane, greatest_lane, advance_mask);
      end else begin
        head_want = decision_q.pop_front();
        n_out++;
        if (joined) n_joins++;
        if (joined !== head_want.joined || representative_lane !== head_want.rep ||
            greatest_lane !== head_want.great || advance_mask !== head_want.adv) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"ERROR: result %0d exp match=%0d rep=%0d great=%0d adv=%h,",
                      " got %0d %0d %0d %h"},
                     n_out, head_want.joined, head_want.rep, head_want.great,
                     head_want.adv, joined, representative_lane, greatest_lane,
                     advance_mask);
        end
      end
    end
  end

  initial begin
    #(12 * 400000);
    $display("** multiway_sorted_key_join_step_top: FAILED **");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    lanes_we      = 1'b0;
    lanes_wr_data = '0;
    in_valid      = 1'b0;
    lane_0_record = '0;
    lane_1_record = '0;
    lane_2_record = '0;
    lane_3_record = '0;
    idle_on       = 1'b1;
    stall_reqs    = 0;
    mismatches    = 0;
    n_in          = 0;
    n_out         = 0;
    n_joins       = 0;
    lanes_now     = msj_pkg::RESET_LANES;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      if (STEP_ROWS[r].lanes != lanes_now) write_lanes(STEP_ROWS[r].lanes);
      send_heads(STEP_ROWS[r].heads, STEP_ROWS[r].typed, STEP_ROWS[r].want);
    end

    for (int p = 0; p < 8; p++) begin
      write_lanes(PHASE_LANES[p]);
      idle_on = (p != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 40) stall_reqs <= stall_reqs + 1;
        send_heads(random_heads(), 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    idle_on = 1'b1;

    while (decision_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d transfers in over lane-count settings 0..7, directed and random.",
             n_in);
    $display("Checked %0d decisions (%0d joins), %0d mismatches.", n_out, n_joins, mismatches);
    if (mismatches == 0) begin
      $display("** multiway_sorted_key_join_step_top: PASSED **");
    end else begin
      $display("** multiway_sorted_key_join_step_top: FAILED **");
    end
    $finish;
  end

endmodule
